### src/hlmd_pkg.sv
// ----------------------------------------------------------------------------
// hlmd_pkg
// Shared widths and reset value for the height map local minimum detector.
// ----------------------------------------------------------------------------
package hlmd_pkg;

  // field widths of the pixel, result and size register beats
  localparam int unsigned HeightW  = 8;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned MapSizeW = 11;

  // map side length after reset
  localparam logic [MapSizeW-1:0] MapSizeReset = 11'd256;

  // rows of the 3x3 window
  localparam int unsigned WinRows = 3;

endpackage

### src/hlmd_ram.sv
// ----------------------------------------------------------------------------
// hlmd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (read-first when both ports hit the same entry).
// ----------------------------------------------------------------------------
module hlmd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/heightmap_local_minimum_detect_core.sv
// ----------------------------------------------------------------------------
// heightmap_local_minimum_detect_core
// Streaming 3x3 local minimum detector for a square 8-bit height map.
// ----------------------------------------------------------------------------
// Pixels enter in row-major order at one per clock cycle, sustained, with
// no gaps at row or map boundaries; the input stalls only while a result
// beat waits unaccepted in the output register. A pixel at column c, row r
// (both at least 2) completes the window centered on column c-1, row r-1;
// if that center is no higher than each of its eight neighbors, the result
// beat (column, row, height) goes to the output register as the completing
// pixel leaves stage 1. The rate is set by the single line-store RAM,
// which is read once and written once per pixel; a forwarding register
// covers the case where consecutive pixels hit the same entry
// (one-pixel-wide maps). Border pixels never report. The map side length
// is clamped to 1..MAX_SIZE and should be written only while the block is
// idle. The line store needs no clearing after reset; a new map should
// start with frame_start set or follow a complete map.
// ----------------------------------------------------------------------------
module heightmap_local_minimum_detect_core
  import hlmd_pkg::*;
#(
  parameter int unsigned MAX_SIZE = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // size register write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [MapSizeW-1:0] map_size_i,
  // pixel input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                frame_start_i,
  input  logic [HeightW-1:0]  height_i,
  // minimum output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CoordW-1:0]   column_o,
  output logic [CoordW-1:0]   row_o,
  output logic [HeightW-1:0]  min_height_o
);

  localparam int unsigned AW = $clog2(MAX_SIZE);
  localparam int unsigned SW = $clog2(MAX_SIZE + 1);
  localparam int unsigned XW = (SW > MapSizeW) ? SW : MapSizeW;
  localparam int unsigned PW = (AW > CoordW) ? AW : CoordW;
  localparam int unsigned LW = 2 * HeightW;

  // size register
  logic [MapSizeW-1:0] map_size_q;
  logic [XW-1:0]       map_size_x;
  logic [XW-1:0]       eff_size;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q <= MapSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      map_size_q <= map_size_i;
    end
  end

  // clamp to 1..MAX_SIZE
  always_comb begin
    map_size_x = XW'(map_size_q);
    if (map_size_q == '0) begin
      eff_size = XW'(1);
    end else if (map_size_x > XW'(MAX_SIZE)) begin
      eff_size = XW'(MAX_SIZE);
    end else begin
      eff_size = map_size_x;
    end
  end

  // pipeline advance: output register free or being drained
  logic pipe_en;
  logic accept;
  logic out_valid_q;

  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;
  assign accept     = in_valid_i && in_ready_o;

  // position counters
  logic [AW-1:0] col_q, col_d, row_q, row_d;
  logic [AW-1:0] c_cur, r_cur;
  logic [XW-1:0] c_inc, r_inc;
  logic          in_map;

  assign c_cur  = frame_start_i ? '0 : col_q;
  assign r_cur  = frame_start_i ? '0 : row_q;
  assign c_inc  = XW'(c_cur) + XW'(1);
  assign r_inc  = XW'(r_cur) + XW'(1);
  assign in_map = (XW'(c_cur) < eff_size) && (XW'(r_cur) < eff_size);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (c_inc >= eff_size) begin
        col_d = '0;
        row_d = (r_inc >= eff_size) ? '0 : r_inc[AW-1:0];
      end else begin
        col_d = c_inc[AW-1:0];
        row_d = r_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 registers: pixel waiting for its line-store read
  logic               s1_valid_q;
  logic               s1_inmap_q;
  logic [AW-1:0]      s1_col_q;
  logic [AW-1:0]      s1_row_q;
  logic [HeightW-1:0] s1_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_inmap_q  <= in_map;
      s1_col_q    <= c_cur;
      s1_row_q    <= r_cur;
      s1_height_q <= height_i;
    end
  end

  // line store: upper line in the high byte, middle line in the low byte
  logic          ram_re;
  logic          ram_we;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] line_rd;
  logic          advance;
  logic          shift;

  assign advance = pipe_en && s1_valid_q;
  assign shift   = advance && s1_inmap_q;
  assign ram_re  = accept && in_map;
  assign ram_we  = shift;

  hlmd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_SIZE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (c_cur),
    .rdata_o (ram_rdata)
  );

  // forward the write that lands on the entry being read in the same cycle
  logic          fwd_q;
  logic          fwd_d;
  logic [LW-1:0] fwd_data_q;

  assign fwd_d = ram_we && (s1_col_q == c_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (ram_re) begin
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      fwd_data_q <= ram_wdata;
    end
  end

  assign line_rd   = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata = {line_rd[HeightW-1:0], s1_height_q};

  // window: two stored columns plus the incoming one
  logic [HeightW-1:0] win1_q [WinRows];
  logic [HeightW-1:0] win2_q [WinRows];
  logic [HeightW-1:0] new_col [WinRows];

  assign new_col[0] = line_rd[LW-1:HeightW];
  assign new_col[1] = line_rd[HeightW-1:0];
  assign new_col[2] = s1_height_q;

  always_ff @(posedge clk_i) begin
    if (shift) begin
      for (int i = 0; i < WinRows; i++) begin
        win1_q[i] <= win2_q[i];
        win2_q[i] <= new_col[i];
      end
    end
  end

  // center against its eight neighbors
  logic [HeightW-1:0] center;
  logic               is_min;
  logic               found;

  assign center = win2_q[1];

  always_comb begin
    is_min = 1'b1;
    for (int i = 0; i < WinRows; i++) begin
      if ((center > win1_q[i]) || (center > win2_q[i]) || (center > new_col[i])) begin
        is_min = 1'b0;
      end
    end
  end

  assign found = s1_inmap_q && (s1_col_q >= AW'(2)) && (s1_row_q >= AW'(2)) && is_min;

  // output register
  logic [PW-1:0]      col_m1;
  logic [PW-1:0]      row_m1;
  logic [CoordW-1:0]  column_q;
  logic [CoordW-1:0]  row_out_q;
  logic [HeightW-1:0] min_height_q;

  assign col_m1 = PW'(s1_col_q) - PW'(1);
  assign row_m1 = PW'(s1_row_q) - PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= advance && found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && found) begin
      column_q     <= col_m1[CoordW-1:0];
      row_out_q    <= row_m1[CoordW-1:0];
      min_height_q <= center;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_o     = column_q;
  assign row_o        = row_out_q;
  assign min_height_o = min_height_q;

  // a frame start places the pixel at the map origin
  a_frame_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_start_i |=> s1_valid_q && s1_col_q == '0 && s1_row_q == '0)
    else $error("frame start did not restart position");

  // a stalled stage 1 keeps its pixel
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en && s1_valid_q |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_height_q))
    else $error("stage 1 pixel lost during stall");

  // a new result comes only from an in-map stage 1 pixel
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_inmap_q))
    else $error("result without a source pixel");

  // no line-store read or write while the output stalls
  a_no_write_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !ram_we && !ram_re)
    else $error("line store accessed during stall");

endmodule

### verif/heightmap_local_minimum_detect_core_tb.sv
// ----------------------------------------------------------------------------
// heightmap_local_minimum_detect_core_tb
// Self-checking bench for the streaming 3x3 height map minimum detector.
// ----------------------------------------------------------------------------
// Pixel beats are queued by the stimulus block and offered by a clocked
// driver. Every accepted pixel is run through a local copy of the line
// stores, window and counters, which queues the minimum it completes. The
// monitor checks each result beat against the oldest queued minimum. The
// run covers the reset size, hand-made windows, size clamping at both ends,
// shrinking in mid-map, maps that follow without frame_start, and random
// small maps under several backpressure patterns.
// ----------------------------------------------------------------------------
module heightmap_local_minimum_detect_core_tb;
  import hlmd_pkg::*;

  localparam int unsigned MaxSize    = 1024;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned Latency    = 8;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandItems  = 270;

  typedef enum int {HT_FULL, HT_TIES, HT_EXTREME} height_mode_e;

  typedef struct packed {
    logic                frame_start;
    logic [HeightW-1:0]  height;
  } pixel_t;

  typedef struct packed {
    logic [CoordW-1:0]  column;
    logic [CoordW-1:0]  row;
    logic [HeightW-1:0] height;
  } minimum_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [MapSizeW-1:0] map_size_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                frame_start_i = 1'b0;
  logic [HeightW-1:0]  height_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [CoordW-1:0]   column_o;
  logic [CoordW-1:0]   row_o;
  logic [HeightW-1:0]  min_height_o;

  heightmap_local_minimum_detect_core #(
    .MAX_SIZE(MaxSize)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .map_size_i   (map_size_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_start_i(frame_start_i),
    .height_i     (height_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .column_o     (column_o),
    .row_o        (row_o),
    .min_height_o (min_height_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predicted detector state
  // ---------------------------------------------------------------------------
  logic [HeightW-1:0]  upper_row  [MaxSize];
  logic [HeightW-1:0]  middle_row [MaxSize];
  logic [HeightW-1:0]  win [3][3];
  int unsigned         col_cnt  = 0;
  int unsigned         row_cnt  = 0;
  logic [MapSizeW-1:0] side_reg = MapSizeReset;

  pixel_t      pixel_q[$];
  minimum_t    minima_q[$];
  int unsigned pushed_cnt = 0;
  int unsigned taken_cnt  = 0;

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 7;
  int unsigned recv_idle_pct  = 54;
  bit          hold_armed     = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  // side length clamped to 1..MaxSize
  function automatic int unsigned side_len();
    int unsigned s;
    s = 32'(side_reg);
    if (s < 1) s = 1;
    if (s > MaxSize) s = MaxSize;
    return s;
  endfunction

  // advance the window by one pixel and queue the minimum it completes
  task automatic predict_minimum(input logic fs, input logic [HeightW-1:0] h);
    int unsigned side;
    int unsigned c;
    int unsigned r;
    logic [HeightW-1:0] centre;
    bit lowest;
    minimum_t m;
    side = side_len();
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    if (c < side && r < side) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = upper_row[c];
      win[1][2] = middle_row[c];
      win[2][2] = h;
      upper_row[c]  = middle_row[c];
      middle_row[c] = h;
      if (c >= 2 && r >= 2) begin
        centre = win[1][1];
        lowest = 1'b1;
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            if (centre > win[i][j]) lowest = 1'b0;
          end
        end
        if (lowest) begin
          m.column = CoordW'(c - 1);
          m.row    = CoordW'(r - 1);
          m.height = centre;
          minima_q.insert(minima_q.size(), m);
        end
      end
    end
    col_cnt = c + 1;
    if (col_cnt >= side) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= side) row_cnt = 0;
    end
  endtask

  // one line per mismatch
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // compare a result beat with the oldest predicted minimum
  task automatic check_minimum();
    minimum_t want;
    if (minima_q.size() == 0) begin
      report_mismatch("minimum with none pending, column", 32'(column_o), 0);
    end else begin
      want = minima_q.pop_front();
      if (column_o !== want.column) begin
        report_mismatch("column", 32'(column_o), 32'(want.column));
      end
      if (row_o !== want.row) report_mismatch("row", 32'(row_o), 32'(want.row));
      if (min_height_o !== want.height) begin
        report_mismatch("min_height", 32'(min_height_o), 32'(want.height));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // pixel driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t p;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_minimum(frame_start_i, height_i);
        taken_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pixel_q.pop_front();
          in_valid_i    <= 1'b1;
          frame_start_i <= p.frame_start;
          height_i      <= p.height;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver backpressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_minimum();
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (hold_armed) begin
        hold_armed  = 1'b0;
        hold_left   <= HoldCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [HeightW-1:0] pick_height(input height_mode_e mode);
    case (mode)
      HT_TIES:    return HeightW'($urandom_range(3));
      HT_EXTREME: return $urandom_range(1) ? {HeightW{1'b1}} : '0;
      default:    return HeightW'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_pixel(input logic fs, input logic [HeightW-1:0] h);
    pixel_t p;
    p.frame_start = fs;
    p.height      = h;
    pixel_q.insert(pixel_q.size(), p);
    pushed_cnt++;
  endtask

  // n pixels; a stray frame_start restarts the count so the map still completes
  task automatic queue_run(input int unsigned n, input logic first_fs,
                           input height_mode_e mode, input bit noise);
    int unsigned k;
    logic fs;
    k = 0;
    while (k < n) begin
      fs = (k == 0) ? first_fs : (noise && $urandom_range(99) == 0);
      if (fs) k = 0;
      queue_pixel(fs, pick_height(mode));
      k++;
    end
  endtask

  // one 3x3 map from a fixed grid
  task automatic queue_grid(input logic [HeightW-1:0] cells [9]);
    for (int i = 0; i < 9; i++) queue_pixel(i == 0, cells[i]);
  endtask

  // wait until every pixel is taken and every minimum has come out
  task automatic wait_drained(input int unsigned settle);
    do @(posedge clk_i);
    while (taken_cnt != pushed_cnt || minima_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_map_size(input logic [MapSizeW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    map_size_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    side_reg = v;
  endtask

  // shrink in mid-map, finish the map at the new size, then queue one more full map, both without frame_start
  task automatic shrink_mid_map(input logic [MapSizeW-1:0] v);
    int unsigned n;
    int unsigned c;
    int unsigned r;
    int unsigned s;
    wait_drained(Latency);
    write_map_size(v);
    s = side_len();
    c = col_cnt;
    r = row_cnt;
    n = 0;
    do begin
      n++;
      c++;
      if (c >= s) begin
        c = 0;
        r++;
        if (r >= s) r = 0;
      end
    end while (c != 0 || r != 0);
    queue_run(n, 1'b0, HT_FULL, 1'b0);
    queue_run(s * s, 1'b0, HT_TIES, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned  phase_items;
    int unsigned  side;
    int unsigned  eff;
    int unsigned  nmaps;
    height_mode_e mode;
    bit           hold_done;
    bit           pause_done;
    bit           pause_now;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset size: part of a row wider than the later map, then shrink
    queue_run(20, 1'b1, HT_FULL, 1'b0);
    shrink_mid_map(11'd4);

    // hand-made windows: deep pit, one lower neighbor, flat plateau
    wait_drained(Latency);
    write_map_size(11'd3);
    queue_grid('{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
    queue_grid('{8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    queue_grid('{default: 8'd128});

    // zero size clamps to a single pixel
    wait_drained(Latency);
    write_map_size(11'd0);
    queue_run(2, 1'b1, HT_FULL, 1'b0);

    // all-ones size clamps to the maximum; a short row, then shrink
    wait_drained(Latency);
    write_map_size({MapSizeW{1'b1}});
    queue_run(20, 1'b1, HT_FULL, 1'b0);
    shrink_mid_map(11'd5);

    // random small maps in three backpressure phases
    hold_done  = 1'b0;
    pause_done = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin
        send_idle_pct = 7;
        recv_idle_pct = 54;
      end else if (ph == 1) begin
        send_idle_pct = 54;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_items = 0;
      while (phase_items < RandItems / 3) begin
        side  = ($urandom_range(99) < 8) ? $urandom_range(2) : $urandom_range(3, 12);
        nmaps = $urandom_range(1, 2);
        mode  = height_mode_e'($urandom_range(2));
        pause_now = 1'b0;
        if (!hold_done) begin
          side  = 10;
          nmaps = 1;
          mode  = HT_TIES;
        end else if (!pause_done && ph == 2) begin
          side = 7;
          nmaps = 2;
          pause_now = 1'b1;
          pause_done = 1'b1;
        end
        wait_drained(Latency);
        write_map_size(MapSizeW'(side));
        eff = side_len();
        if (!hold_done) begin
          hold_armed = 1'b1;
          hold_done  = 1'b1;
        end
        for (int m = 0; m < nmaps; m++) begin
          if (pause_now && m != 0) wait_drained(0);
          queue_run(eff * eff, (m == 0) ? 1'b1 : logic'($urandom_range(1)), mode, 1'b1);
          phase_items += eff * eff;
        end
      end
    end

    wait_drained(Latency);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
